// ===== design/msee_pkg.sv =====
// shared types and constants for the multitouch slot event encoder
// no dependencies
`timescale 1ns / 1ps

package msee_pkg;

  localparam int SLOT_COUNT_DEF = 10;
  localparam int TRACK_MOD_DEF  = 10;

  localparam int ID_W    = 5;
  localparam int COORD_W = 16;
  localparam int VALUE_W = 17;

  localparam logic [1:0] CMD_DOWN   = 2'd0;
  localparam logic [1:0] CMD_UP     = 2'd1;
  localparam logic [1:0] CMD_MOTION = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] EV_TYPE_SYN = 2'd0;
  localparam logic [1:0] EV_TYPE_ABS = 2'd3;

  localparam logic [5:0] CODE_SLOT   = 6'h2f;
  localparam logic [5:0] CODE_TRACK  = 6'h39;
  localparam logic [5:0] CODE_X      = 6'h35;
  localparam logic [5:0] CODE_Y      = 6'h36;
  localparam logic [5:0] CODE_REPORT = 6'h00;

  localparam logic [VALUE_W-1:0] VALUE_RELEASE = '1;

  // write request into the slot table
  typedef struct packed {
    logic            en;
    logic            in_use;
    logic [ID_W-1:0] owner;
  } slot_wr_t;

endpackage

// ===== design/msee_slot_table.sv =====
// slot table: owner id and in-use flag per slot, one read and one write port
// depends on msee_pkg
`timescale 1ns / 1ps

module msee_slot_table #(
  parameter int SLOT_COUNT = msee_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SLOT_W-1:0]         rd_idx,
  output logic [msee_pkg::ID_W-1:0] rd_owner,
  output logic                      rd_in_use,
  input  logic [SLOT_W-1:0]         wr_idx,
  input  msee_pkg::slot_wr_t        wr
);
  import msee_pkg::*;

  logic [ID_W-1:0] owner_r  [SLOT_COUNT];
  logic            in_use_r [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        owner_r[i]  <= '0;
        in_use_r[i] <= 1'b0;
      end
    end else if (wr.en) begin
      owner_r[wr_idx]  <= wr.owner;
      in_use_r[wr_idx] <= wr.in_use;
    end
  end

  assign rd_owner  = owner_r[rd_idx];
  assign rd_in_use = in_use_r[rd_idx];

endmodule

// ===== design/multitouch_slot_event_encoder.sv =====
// multitouch slot event encoder: finger events in, slot protocol words out
// sequence: an accept in idle, then a slot scan of 1 to SLOT_COUNT slots (one slot per
//   cycle through a shared compare; the id mod reduction runs alongside and can hold the
//   scan open until it is done), then 2 to 5 output words, one per cycle while out_stall is low
// throughput: one item at a time; the next item is taken the cycle after the last word
// reset: synchronous, clears the slot table and the announced slot
// depends on msee_pkg, msee_slot_table
`timescale 1ns / 1ps

module multitouch_slot_event_encoder #(
  parameter int SLOT_COUNT       = msee_pkg::SLOT_COUNT_DEF,
  parameter int TRACKING_MODULUS = msee_pkg::TRACK_MOD_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_cmd,
  input  logic [msee_pkg::ID_W-1:0]          in_touch_id,
  input  logic [msee_pkg::COORD_W-1:0]       in_x_position,
  input  logic [msee_pkg::COORD_W-1:0]       in_y_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_event_type,
  output logic [5:0]                         out_event_code,
  output logic signed [msee_pkg::VALUE_W-1:0] out_event_value,
  output logic                               out_last_event
);
  import msee_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int REM_W  = ID_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef enum logic [4:0] {
    EVK_SLOT  = 5'b00001,
    EVK_TRACK = 5'b00010,
    EVK_X     = 5'b00100,
    EVK_Y     = 5'b01000,
    EVK_SYNC  = 5'b10000
  } kind_t;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [ID_W-1:0]     rem_r, rem_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_W-1:0]   ann_slot_r, ann_slot_nxt;
  logic                ann_valid_r, ann_valid_nxt;

  logic [ID_W-1:0]     rd_owner;
  logic                rd_in_use;
  slot_wr_t            tbl_wr;
  logic [SLOT_W-1:0]   tbl_wr_idx;

  logic                hit, last_idx, mod_busy, fin, got;
  logic [SLOT_W-1:0]   sel;

  msee_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .rd_owner  (rd_owner),
    .rd_in_use (rd_in_use),
    .wr_idx    (tbl_wr_idx),
    .wr        (tbl_wr)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  // shared compare: a down looks for a free slot, up and motion for the owner
  assign hit      = (cmd_r == CMD_DOWN) ? !rd_in_use : (rd_in_use && (rd_owner == id_r));
  assign last_idx = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign mod_busy = ({1'b0, rem_r} >= REM_W'(TRACKING_MODULUS));
  assign fin      = found_r || hit || last_idx;
  assign got      = found_r || hit;
  assign sel      = found_r ? slot_r : idx_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    ann_slot_nxt  = ann_slot_r;
    ann_valid_nxt = ann_valid_r;
    tbl_wr        = '0;
    tbl_wr_idx    = sel;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_cmd != CMD_UNUSED)) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_touch_id;
          x_nxt     = in_x_position;
          y_nxt     = in_y_position;
          rem_nxt   = in_touch_id;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (mod_busy) begin
          rem_nxt = rem_r - ID_W'(TRACKING_MODULUS);
        end
        if (hit && !found_r) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
        end
        if (!fin) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (fin && !mod_busy) begin
          if (got) begin
            tbl_wr.en     = (cmd_r != CMD_MOTION);
            tbl_wr.in_use = (cmd_r == CMD_DOWN);
            tbl_wr.owner  = (cmd_r == CMD_DOWN) ? id_r : '0;
            slot_nxt      = sel;
            ann_slot_nxt  = sel;
            ann_valid_nxt = 1'b1;
            if (!ann_valid_r || (ann_slot_r != sel)) begin
              kind_nxt = EVK_SLOT;
            end else if (cmd_r == CMD_MOTION) begin
              kind_nxt = EVK_X;
            end else begin
              kind_nxt = EVK_TRACK;
            end
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          case (kind_r)
            EVK_SLOT:  kind_nxt = (cmd_r == CMD_MOTION) ? EVK_X : EVK_TRACK;
            EVK_TRACK: kind_nxt = (cmd_r == CMD_DOWN) ? EVK_X : EVK_SYNC;
            EVK_X:     kind_nxt = EVK_Y;
            EVK_Y:     kind_nxt = EVK_SYNC;
            default:   kind_nxt = EVK_SYNC;
          endcase
          if (kind_r == EVK_SYNC) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ann_slot_r  <= '0;
      ann_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ann_slot_r  <= ann_slot_nxt;
      ann_valid_r <= ann_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
  end

  // output word built from held registers, so it holds while stalled
  always_comb begin
    out_event_type  = EV_TYPE_ABS;
    out_event_code  = CODE_REPORT;
    out_event_value = '0;
    out_last_event  = 1'b0;
    case (kind_r)
      EVK_SLOT: begin
        out_event_code  = CODE_SLOT;
        out_event_value = VALUE_W'(slot_r);
      end
      EVK_TRACK: begin
        out_event_code  = CODE_TRACK;
        out_event_value = (cmd_r == CMD_UP) ? VALUE_RELEASE
                                            : VALUE_W'(rem_r) + VALUE_W'(1);
      end
      EVK_X: begin
        out_event_code  = CODE_X;
        out_event_value = VALUE_W'(x_r);
      end
      EVK_Y: begin
        out_event_code  = CODE_Y;
        out_event_value = VALUE_W'(y_r);
      end
      default: begin
        out_event_type  = EV_TYPE_SYN;
        out_event_code  = CODE_REPORT;
        out_event_value = '0;
        out_last_event  = 1'b1;
      end
    endcase
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_valid && !in_stall && (in_cmd != CMD_UNUSED)) |=> in_stall)
    else $error("accepted item did not hold off the input");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && !out_stall && out_last_event) |=> (!out_valid && !in_stall))
    else $error("sequence did not end after the sync word");

  a_ann_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ann_valid_r && (ann_slot_r == slot_r)))
    else $error("announced slot out of step with emitted slot");

endmodule

// ===== dv/multitouch_slot_event_encoder_test.sv =====
// self-checking bench for the multitouch slot event encoder: scripted finger events,
// then random ones, every output word checked against hand-written words or a slot-table predictor
// depends on msee_pkg and multitouch_slot_event_encoder
`timescale 1ns / 1ps

module multitouch_slot_event_encoder_test;
  import msee_pkg::*;

  localparam int NSLOT         = SLOT_COUNT_DEF;
  localparam int TMOD          = TRACK_MOD_DEF;
  localparam int RANDOM_EVENTS = 296;
  localparam int CALM_AFTER    = 260;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LIMIT         = 400000;
  localparam logic [2:0] BY_MODEL = 3'd7;

  typedef struct packed {
    logic [1:0]         etype;
    logic [5:0]         ecode;
    logic [VALUE_W-1:0] evalue;
    logic               last;
  } touch_word_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [2:0]         ntyped;
  } touch_row_t;

  // scripted events; ntyped gives the count of hand-written words, BY_MODEL uses the predictor
  localparam touch_row_t SCRIPT [24] = '{
    '{CMD_DOWN,   5'd0,  16'h0000, 16'h0000, 3'd5},
    '{CMD_MOTION, 5'd0,  16'hffff, 16'hffff, 3'd3},
    '{CMD_UP,     5'd5,  16'h1111, 16'h2222, 3'd0},
    '{CMD_UNUSED, 5'd0,  16'h0000, 16'h0000, 3'd0},
    '{CMD_DOWN,   5'd31, 16'hffff, 16'h0000, 3'd5},
    '{CMD_UP,     5'd31, 16'h0000, 16'hffff, 3'd2},
    '{CMD_MOTION, 5'd0,  16'h1234, 16'h5678, BY_MODEL},
    '{CMD_DOWN,   5'd9,  16'h8000, 16'h0001, BY_MODEL},
    '{CMD_DOWN,   5'd10, 16'h0001, 16'h8000, BY_MODEL},
    '{CMD_DOWN,   5'd19, 16'h5555, 16'haaaa, BY_MODEL},
    '{CMD_DOWN,   5'd20, 16'haaaa, 16'h5555, BY_MODEL},
    '{CMD_DOWN,   5'd29, 16'h0f0f, 16'hf0f0, BY_MODEL},
    '{CMD_DOWN,   5'd30, 16'hf0f0, 16'h0f0f, BY_MODEL},
    '{CMD_DOWN,   5'd0,  16'h7fff, 16'hfffe, BY_MODEL},
    '{CMD_DOWN,   5'd31, 16'hfffe, 16'h7fff, BY_MODEL},
    '{CMD_DOWN,   5'd15, 16'h00ff, 16'hff00, BY_MODEL},
    '{CMD_DOWN,   5'd7,  16'h4321, 16'h8765, 3'd0},
    '{CMD_MOTION, 5'd0,  16'h0102, 16'h0304, BY_MODEL},
    '{CMD_UP,     5'd0,  16'h0000, 16'h0000, BY_MODEL},
    '{CMD_MOTION, 5'd0,  16'hbeef, 16'hcafe, BY_MODEL},
    '{CMD_UP,     5'd0,  16'h0000, 16'h0000, BY_MODEL},
    '{CMD_UP,     5'd0,  16'h0000, 16'h0000, 3'd0},
    '{CMD_DOWN,   5'd3,  16'h3333, 16'hcccc, BY_MODEL},
    '{CMD_UNUSED, 5'd31, 16'hffff, 16'hffff, 3'd0}
  };

  localparam touch_word_t TYPED_WORDS [15] = '{
    '{EV_TYPE_ABS, CODE_SLOT,   17'd0,       1'b0},
    '{EV_TYPE_ABS, CODE_TRACK,  17'd1,       1'b0},
    '{EV_TYPE_ABS, CODE_X,      17'h00000,   1'b0},
    '{EV_TYPE_ABS, CODE_Y,      17'h00000,   1'b0},
    '{EV_TYPE_SYN, CODE_REPORT, 17'd0,       1'b1},
    '{EV_TYPE_ABS, CODE_X,      17'h0ffff,   1'b0},
    '{EV_TYPE_ABS, CODE_Y,      17'h0ffff,   1'b0},
    '{EV_TYPE_SYN, CODE_REPORT, 17'd0,       1'b1},
    '{EV_TYPE_ABS, CODE_SLOT,   17'd1,       1'b0},
    '{EV_TYPE_ABS, CODE_TRACK,  17'd2,       1'b0},
    '{EV_TYPE_ABS, CODE_X,      17'h0ffff,   1'b0},
    '{EV_TYPE_ABS, CODE_Y,      17'h00000,   1'b0},
    '{EV_TYPE_SYN, CODE_REPORT, 17'd0,       1'b1},
    '{EV_TYPE_ABS, CODE_TRACK,  VALUE_RELEASE, 1'b0},
    '{EV_TYPE_SYN, CODE_REPORT, 17'd0,       1'b1}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_DOWN;
  logic [ID_W-1:0] in_touch_id = '0;
  logic [COORD_W-1:0] in_x_position = '0;
  logic [COORD_W-1:0] in_y_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_event_type;
  logic [5:0] out_event_code;
  logic signed [VALUE_W-1:0] out_event_value;
  logic out_last_event;

  multitouch_slot_event_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_touch_id    (in_touch_id),
    .in_x_position  (in_x_position),
    .in_y_position  (in_y_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_type (out_event_type),
    .out_event_code (out_event_code),
    .out_event_value(out_event_value),
    .out_last_event (out_last_event)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: slot table and the slot last selected downstream
  logic            slot_busy [NSLOT];
  logic [ID_W-1:0] slot_finger [NSLOT];
  logic [3:0]      shown_slot;
  logic            shown_valid;
  touch_word_t     pred_words [5];
  int              pred_n;

  touch_word_t pending_words [$];
  int errors = 0;
  int words_checked = 0;
  int events_sent = 0;
  int events_dropped = 0;
  int typed_at = 0;
  int idle_pct = 20;
  int stall_pct = 20;
  int hold_left = 0;
  int cycles = 0;

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic void emit_word(logic [1:0] etype, logic [5:0] ecode,
                                    logic [VALUE_W-1:0] evalue, logic last);
    pred_words[pred_n] = '{etype, ecode, evalue, last};
    pred_n++;
  endfunction

  function automatic void select_slot(int slot);
    if (!shown_valid || shown_slot != 4'(slot)) begin
      emit_word(EV_TYPE_ABS, CODE_SLOT, VALUE_W'(slot), 1'b0);
      shown_slot = 4'(slot);
      shown_valid = 1'b1;
    end
  endfunction

  // works out the words one finger event causes and updates the slot table
  function automatic int predict_touch(logic [1:0] cmd, logic [ID_W-1:0] id,
                                       logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int slot;
    int i;
    slot = -1;
    pred_n = 0;
    if (cmd == CMD_DOWN) begin
      // lowest free slot wins
      for (i = NSLOT - 1; i >= 0; i--) if (!slot_busy[i]) slot = i;
      if (slot >= 0) begin
        slot_busy[slot] = 1'b1;
        slot_finger[slot] = id;
        select_slot(slot);
        emit_word(EV_TYPE_ABS, CODE_TRACK, VALUE_W'(int'(id) % TMOD + 1), 1'b0);
        emit_word(EV_TYPE_ABS, CODE_X, VALUE_W'(x), 1'b0);
        emit_word(EV_TYPE_ABS, CODE_Y, VALUE_W'(y), 1'b0);
        emit_word(EV_TYPE_SYN, CODE_REPORT, '0, 1'b1);
      end
    end else if (cmd == CMD_UP || cmd == CMD_MOTION) begin
      // a finger held twice acts on its lowest slot
      for (i = NSLOT - 1; i >= 0; i--) if (slot_busy[i] && slot_finger[i] == id) slot = i;
      if (slot >= 0) begin
        select_slot(slot);
        if (cmd == CMD_UP) begin
          emit_word(EV_TYPE_ABS, CODE_TRACK, VALUE_RELEASE, 1'b0);
          slot_busy[slot] = 1'b0;
          slot_finger[slot] = '0;
        end else begin
          emit_word(EV_TYPE_ABS, CODE_X, VALUE_W'(x), 1'b0);
          emit_word(EV_TYPE_ABS, CODE_Y, VALUE_W'(y), 1'b0);
        end
        emit_word(EV_TYPE_SYN, CODE_REPORT, '0, 1'b1);
      end
    end
    return pred_n;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return COORD_W'($urandom_range(65535));
  endfunction

  function automatic int rand_level();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  // hands one finger event to the block, then queues what it should answer
  task automatic send_event(logic [1:0] cmd, logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y, logic [2:0] ntyped, output int nw);
    int gap;
    int k;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(15, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_touch_id <= id;
    in_x_position <= x;
    in_y_position <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nw = predict_touch(cmd, id, x, y);
    if (ntyped == BY_MODEL) begin
      for (k = 0; k < nw; k++) pending_words = {pending_words, pred_words[k]};
    end else begin
      for (k = 0; k < int'(ntyped); k++) begin
        pending_words = {pending_words, TYPED_WORDS[typed_at]};
        typed_at++;
      end
    end
    events_sent++;
    if (nw == 0) events_dropped++;
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      hold_left <= $urandom_range(15, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    touch_word_t got;
    touch_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_event_type, out_event_code, out_event_value, out_last_event};
      words_checked++;
      if (pending_words.size() == 0) begin
        note_error($sformatf("unexpected word: type %0d code %h value %h last %0d",
                             got.etype, got.ecode, got.evalue, got.last));
      end else begin
        want = pending_words.pop_front();
        if (got !== want)
          note_error($sformatf({"word %0d: expected type %0d code %h value %h last %0d,",
                                " got type %0d code %h value %h last %0d"},
                               words_checked, want.etype, want.ecode, want.evalue, want.last,
                               got.etype, got.ecode, got.evalue, got.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timed out with %0d words outstanding", pending_words.size());
      $display("multitouch_slot_event_encoder_test: FAIL");
      $finish;
    end
  end

  initial begin
    int row;
    int nw;
    int live;
    int phase;
    int pick;
    int nbusy;
    int i;
    logic [1:0] cmd;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] held;

    for (i = 0; i < NSLOT; i++) begin
      slot_busy[i] = 1'b0;
      slot_finger[i] = '0;
    end
    shown_slot = '0;
    shown_valid = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < 24; row++)
      send_event(SCRIPT[row].cmd, SCRIPT[row].id, SCRIPT[row].x, SCRIPT[row].y,
                 SCRIPT[row].ntyped, nw);

    live = 0;
    phase = -1;
    while (live < RANDOM_EVENTS) begin
      if (live >= CALM_AFTER) begin
        idle_pct = 0;
        stall_pct <= 0;
      end else if (live / 40 != phase) begin
        phase = live / 40;
        idle_pct = rand_level();
        stall_pct <= rand_level();
      end
      // pick a finger that currently holds a slot, for ups and motions
      nbusy = 0;
      held = '0;
      for (i = 0; i < NSLOT; i++)
        if (slot_busy[i]) begin
          nbusy++;
          if ($urandom_range(nbusy - 1) == 0) held = slot_finger[i];
        end
      pick = $urandom_range(99);
      id = ID_W'($urandom_range(31));
      if (pick < 5) begin
        cmd = CMD_UNUSED;
      end else if (pick < 35) begin
        cmd = CMD_DOWN;
      end else begin
        cmd = (pick < 62) ? CMD_UP : CMD_MOTION;
        if (nbusy != 0 && $urandom_range(99) < 85) id = held;
      end
      send_event(cmd, id, rand_coord(), rand_coord(), BY_MODEL, nw);
      live++;
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d finger events (%0d left silent by the encoder), checked %0d words",
             events_sent, events_dropped, words_checked);
    $display("%0d mismatches seen", errors);
    if (errors == 0) begin
      $display("multitouch_slot_event_encoder_test: PASS");
    end else begin
      $display("multitouch_slot_event_encoder_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/msee_pkg.sv
design/msee_slot_table.sv
design/multitouch_slot_event_encoder.sv
dv/multitouch_slot_event_encoder_test.sv
